[hdl/bencode_info_span_locator_unit_assert.svh]
// Assertion macros shared by the checker of the bencode info span locator.
// Each macro builds one labeled concurrent assertion on clk, disabled in reset.
`ifndef BENCODE_INFO_SPAN_LOCATOR_UNIT_ASSERT_SVH
`define BENCODE_INFO_SPAN_LOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BIPL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BIPL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/bipl_pkg.sv]
// Package of the bencode info span locator: sizes, character and state codes, state types.
// No dependencies.
`timescale 1ns / 1ps

package bipl_pkg;

	localparam int MAX_DEPTH = 64;
	localparam int LEN_BITS  = 32;
	localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);

	localparam logic [2:0] KIND_UNKNOWN   = 3'd0;
	localparam logic [2:0] KIND_STR_LEN   = 3'd1;
	localparam logic [2:0] KIND_STR_BODY  = 3'd2;
	localparam logic [2:0] KIND_INT       = 3'd3;
	localparam logic [2:0] KIND_CONTAINER = 3'd4;

	localparam logic [1:0] ST_PARSING = 2'd0;
	localparam logic [1:0] ST_DONE    = 2'd1;
	localparam logic [1:0] ST_FAILED  = 2'd2;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_E_LO  = 8'h65;
	localparam logic [7:0] CH_E_UP  = 8'h45;
	localparam logic [7:0] CH_I_LO  = 8'h69;
	localparam logic [7:0] CH_I_UP  = 8'h49;
	localparam logic [7:0] CH_L_LO  = 8'h6C;
	localparam logic [7:0] CH_L_UP  = 8'h4C;
	localparam logic [7:0] CH_D_LO  = 8'h64;
	localparam logic [7:0] CH_D_UP  = 8'h44;
	localparam logic [7:0] CH_N_LO  = 8'h6E;
	localparam logic [7:0] CH_F_LO  = 8'h66;
	localparam logic [7:0] CH_O_LO  = 8'h6F;

	typedef struct packed {
		logic [DEPTH_W-1:0]  depth;
		logic [2:0]          kind;
		logic [LEN_BITS-1:0] count;
		logic                info_match;
		logic                in_span;
		logic [1:0]          status;
	} bipl_state_t;

	typedef struct packed {
		logic       hash_byte;
		logic       last_hash_byte;
		logic [1:0] status;
	} bipl_result_t;

	function automatic bipl_state_t bipl_reset_state();
		bipl_state_t s;
		s.depth      = DEPTH_W'(1);
		s.kind       = KIND_UNKNOWN;
		s.count      = '0;
		s.info_match = 1'b0;
		s.in_span    = 1'b0;
		s.status     = ST_PARSING;
		return s;
	endfunction

	// Expected character of the word "info" at position idx.
	function automatic logic [7:0] info_char(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0: c = CH_I_LO;
			2'd1: c = CH_N_LO;
			2'd2: c = CH_F_LO;
			default: c = CH_O_LO;
		endcase
		return c;
	endfunction

endpackage

[hdl/bencode_info_span_locator_unit.sv]
// Top level of the bencode info span locator: input register, parse state, result register.
// Depends on bipl_pkg and bipl_step.
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// in        request    in_valid/in_stall   data_byte, start_of_stream
// out       result     out_valid/out_stall hash_byte, last_hash_byte, status
//
// Each byte request yields exactly one result, via the input and then the result register.
// One byte is taken per cycle unless the result side stalls; the single parse-state register,
// updated in the same cycle that moves a byte from input to result register, sets that rate.
// Reset (arst_n low) puts the parser at the root with no span open and empties both registers.
// A stall on the result side holds the result register; the input register then fills,
// and in_stall rises only while both registers are occupied.

module bencode_info_span_locator_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       start_of_stream,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       hash_byte,
	output logic       last_hash_byte,
	output logic [1:0] status
);
	import bipl_pkg::*;

	// Input register holding one accepted byte request.
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         sos_s1;

	// Parse state, updated once per byte that moves on to the result register.
	bipl_state_t  state_q;
	bipl_state_t  state_nxt;
	bipl_result_t res_nxt;
	bipl_result_t res_q;
	logic         out_valid_q;

	logic         advance;
	logic         accept;

	// A byte moves on when the result register is empty or being taken this cycle.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	bipl_step u_step (
		.cur_state       (state_q),
		.data_byte       (byte_s1),
		.start_of_stream (sos_s1),
		.nxt_state       (state_nxt),
		.result          (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= bipl_reset_state();
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
			sos_s1  <= start_of_stream;
		end
		if (advance)
			res_q <= res_nxt;
	end

	assign out_valid      = out_valid_q;
	assign hash_byte      = res_q.hash_byte;
	assign last_hash_byte = res_q.last_hash_byte;
	assign status         = res_q.status;

endmodule

[hdl/bipl_step.sv]
// Next-state and result logic for one byte of the bencode info span locator.
// Purely combinational; uses bipl_pkg.
`timescale 1ns / 1ps

module bipl_step (
	input  bipl_pkg::bipl_state_t  cur_state,
	input  logic [7:0]             data_byte,
	input  logic                   start_of_stream,
	output bipl_pkg::bipl_state_t  nxt_state,
	output bipl_pkg::bipl_result_t result
);
	import bipl_pkg::*;

	bipl_state_t         cur;
	logic [DEPTH_W-1:0]  depth_w;
	logic [2:0]          kind_w;
	logic                done;
	logic                bad;
	logic                is_digit;
	logic                is_end;
	logic [3:0]          dval;
	logic [LEN_BITS+3:0] prod;
	logic [LEN_BITS-1:0] count_dec;
	logic [1:0]          info_idx;

	assign cur       = start_of_stream ? bipl_reset_state() : cur_state;
	assign is_digit  = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
	assign is_end    = (data_byte == CH_E_LO) || (data_byte == CH_E_UP);
	assign dval      = 4'(data_byte - CH_ZERO);
	// count * 10 + digit; any bit above the length field means overflow.
	assign prod      = ({4'b0, cur.count} << 3) + ({4'b0, cur.count} << 1)
		+ (LEN_BITS + 4)'(dval);
	assign count_dec = cur.count - LEN_BITS'(1);
	assign info_idx  = 2'(3'd4 - cur.count[2:0]);

	always_comb begin
		nxt_state = cur;
		result    = '0;
		depth_w   = cur.depth;
		kind_w    = cur.kind;
		done      = 1'b0;
		bad       = 1'b0;
		if (cur.status == ST_PARSING) begin
			if (cur.depth == '0) begin
				bad = 1'b1;
			end else begin
				// An open container either closes or opens a child that reads this byte.
				if (cur.kind == KIND_CONTAINER) begin
					if (is_end) begin
						done = 1'b1;
					end else if (cur.depth >= DEPTH_W'(MAX_DEPTH)) begin
						bad = 1'b1;
					end else begin
						depth_w = cur.depth + DEPTH_W'(1);
						kind_w  = KIND_UNKNOWN;
					end
				end
				if (!done && !bad) begin
					case (kind_w)
						KIND_UNKNOWN: begin
							if (is_digit) begin
								kind_w               = KIND_STR_LEN;
								nxt_state.count      = LEN_BITS'(dval);
								nxt_state.info_match = 1'b0;
							end else if (data_byte == CH_I_LO || data_byte == CH_I_UP) begin
								kind_w = KIND_INT;
							end else if (data_byte == CH_L_LO || data_byte == CH_L_UP
								|| data_byte == CH_D_LO || data_byte == CH_D_UP) begin
								kind_w = KIND_CONTAINER;
							end else begin
								bad = 1'b1;
							end
						end
						KIND_STR_LEN: begin
							if (is_digit) begin
								if (|prod[LEN_BITS+3:LEN_BITS])
									bad = 1'b1;
								else
									nxt_state.count = prod[LEN_BITS-1:0];
							end else if (data_byte == CH_COLON) begin
								nxt_state.info_match = (cur.count == LEN_BITS'(4));
								if (cur.count == '0)
									done = 1'b1;
								else
									kind_w = KIND_STR_BODY;
							end else begin
								bad = 1'b1;
							end
						end
						KIND_STR_BODY: begin
							if (cur.info_match) begin
								if (cur.count >= LEN_BITS'(1) && cur.count <= LEN_BITS'(4)) begin
									if (data_byte != info_char(info_idx))
										nxt_state.info_match = 1'b0;
								end else begin
									nxt_state.info_match = 1'b0;
								end
							end
							nxt_state.count = count_dec;
							if (count_dec == '0)
								done = 1'b1;
						end
						KIND_INT: begin
							if (is_end)
								done = 1'b1;
							else if (!is_digit && data_byte != CH_MINUS)
								bad = 1'b1;
						end
						default: begin
							bad = 1'b1;
						end
					endcase
				end
			end

			nxt_state.depth = depth_w;
			nxt_state.kind  = kind_w;
			if (bad) begin
				nxt_state.status = ST_FAILED;
			end else begin
				result.hash_byte = cur.in_span;
				if (done) begin
					if (!cur.in_span) begin
						if (depth_w == DEPTH_W'(2) && kind_w == KIND_STR_BODY
							&& nxt_state.info_match)
							nxt_state.in_span = 1'b1;
					end else if (depth_w == DEPTH_W'(2)) begin
						result.last_hash_byte = 1'b1;
						nxt_state.in_span     = 1'b0;
						nxt_state.status      = ST_DONE;
					end
					nxt_state.depth      = depth_w - DEPTH_W'(1);
					nxt_state.kind       = (depth_w == DEPTH_W'(1)) ? KIND_UNKNOWN
						: KIND_CONTAINER;
					nxt_state.count      = '0;
					nxt_state.info_match = 1'b0;
				end
			end
		end
		result.status = nxt_state.status;
	end

endmodule

[hdl/bipl_checker.sv]
// Port-level checker for the bencode info span locator, bound to the top level.
// Depends on bipl_pkg and bencode_info_span_locator_unit_assert.svh.
`timescale 1ns / 1ps
`include "bencode_info_span_locator_unit_assert.svh"

module bipl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       hash_byte,
	input logic       last_hash_byte,
	input logic [1:0] status
);
	import bipl_pkg::*;

	// The closing byte of the span is itself hashed and reports success.
	`BIPL_ASSERT_NOW(a_last_is_done, out_valid && last_hash_byte, hash_byte && status == ST_DONE, "last_hash_byte without hash_byte or done status")

	// A failed parse never flags bytes for hashing.
	`BIPL_ASSERT_NOW(a_fail_no_hash, out_valid && status == ST_FAILED, !hash_byte && !last_hash_byte, "hash flag raised on failed parse")

	// A stalled result stays put.
	`BIPL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(hash_byte) && $stable(last_hash_byte) && $stable(status), "stalled result changed")

	// Input stall only rises while a result is waiting.
	`BIPL_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled with free result register")

endmodule

bind bencode_info_span_locator_unit bipl_checker u_bipl_checker (.*);

[verif/bencode_info_span_locator_unit_tb.sv]
// Testbench of bencode_info_span_locator_unit: bencoded byte streams with random pacing,
// each result checked against a byte-level parser kept inside this file.
// Depends on bipl_pkg and bencode_info_span_locator_unit.
`timescale 1ns / 1ps

module bencode_info_span_locator_unit_tb;
	import bipl_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int ITEM_TARGET = 1400;
	// Largest string length that the length field holds.
	localparam logic [63:0] LEN_MAX = 64'({LEN_BITS{1'b1}});
	// The key word, first character in the top byte.
	localparam logic [31:0] INFO_WORD = {CH_I_LO, CH_N_LO, CH_F_LO, CH_O_LO};

	typedef struct packed {
		logic [7:0] data;
		logic       restart;
	} byte_req_t;

	typedef struct packed {
		logic       hash;
		logic       last;
		logic [1:0] st;
	} span_flags_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = 8'h00;
	logic       start_of_stream = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       hash_byte;
	logic       last_hash_byte;
	logic [1:0] status;

	// Requests waiting to be driven, and the flags due for requests already accepted.
	byte_req_t   pending_reqs[$];
	span_flags_t span_flags_due[$];
	// Bytes of the stream under construction; the first one carries start_of_stream.
	logic [7:0]  frame[$];

	byte_req_t   next_req;
	span_flags_t want;
	int          send_gap;
	int          stall_left;
	bit          send_calm;
	bit          recv_calm;
	int          mismatches;
	int          result_count;
	int          cycle_count;

	// Parser state as the block should hold it.
	int unsigned nest_depth;
	logic [2:0]  open_kind;
	logic [63:0] str_left;
	logic        word_hit;
	logic        span_open;
	logic [1:0]  parse_st;

	bencode_info_span_locator_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.data_byte       (data_byte),
		.start_of_stream (start_of_stream),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.hash_byte       (hash_byte),
		.last_hash_byte  (last_hash_byte),
		.status          (status)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Parser prediction
	// ------------------------------------------------------------------

	function automatic void clear_parse();
		nest_depth = 1;
		open_kind  = KIND_UNKNOWN;
		str_left   = '0;
		word_hit   = 1'b0;
		span_open  = 1'b0;
		parse_st   = ST_PARSING;
	endfunction

	function automatic bit is_digit(logic [7:0] b);
		return b >= CH_ZERO && b <= CH_NINE;
	endfunction

	function automatic bit is_close(logic [7:0] b);
		return b == CH_E_LO || b == CH_E_UP;
	endfunction

	// Advances the parser by one byte and returns the flags the block must report for it.
	function automatic span_flags_t locate_span_byte(logic [7:0] b, logic restart);
		span_flags_t r;
		logic        fin;
		logic        bad;
		logic        was_span;
		logic [63:0] digit;
		logic [1:0]  idx;
		r = '0;
		fin = 1'b0;
		bad = 1'b0;
		if (restart)
			clear_parse();
		if (parse_st == ST_PARSING) begin
			was_span = span_open;
			digit = 64'(b - CH_ZERO);
			if (nest_depth == 0) begin
				// The root has already ended, so nothing more may follow.
				bad = 1'b1;
			end else begin
				// Inside a container a close letter ends it; anything else opens a child
				// that then reads this same byte as its first one.
				if (open_kind == KIND_CONTAINER) begin
					if (is_close(b))
						fin = 1'b1;
					else if (nest_depth >= MAX_DEPTH)
						bad = 1'b1;
					else begin
						nest_depth++;
						open_kind = KIND_UNKNOWN;
					end
				end
				if (!fin && !bad) begin
					case (open_kind)
						KIND_UNKNOWN: begin
							if (is_digit(b)) begin
								open_kind = KIND_STR_LEN;
								str_left  = digit;
								word_hit  = 1'b0;
							end else if (b == CH_I_LO || b == CH_I_UP)
								open_kind = KIND_INT;
							else if (b == CH_L_LO || b == CH_L_UP || b == CH_D_LO || b == CH_D_UP)
								open_kind = KIND_CONTAINER;
							else
								bad = 1'b1;
						end
						KIND_STR_LEN: begin
							if (is_digit(b)) begin
								if (str_left > (LEN_MAX - digit) / 10)
									bad = 1'b1;
								else
									str_left = str_left * 10 + digit;
							end else if (b == CH_COLON) begin
								word_hit = (str_left == 4);
								// An empty string is complete on its colon.
								if (str_left == 0)
									fin = 1'b1;
								else
									open_kind = KIND_STR_BODY;
							end else
								bad = 1'b1;
						end
						KIND_STR_BODY: begin
							if (word_hit) begin
								if (str_left >= 1 && str_left <= 4) begin
									idx = 2'(4 - str_left);
									if (b != INFO_WORD[31 - 8 * idx -: 8])
										word_hit = 1'b0;
								end else
									word_hit = 1'b0;
							end
							str_left--;
							if (str_left == 0)
								fin = 1'b1;
						end
						KIND_INT: begin
							// Digits and minus signs in any order until the close letter.
							if (is_close(b))
								fin = 1'b1;
							else if (!is_digit(b) && b != CH_MINUS)
								bad = 1'b1;
						end
						default: bad = 1'b1;
					endcase
				end
			end

			if (bad)
				parse_st = ST_FAILED;
			else begin
				r.hash = was_span;
				if (fin) begin
					// A finished depth-two "info" string opens the span; the next finished
					// depth-two element closes it and ends the parse.
					if (!span_open) begin
						if (nest_depth == 2 && open_kind == KIND_STR_BODY && word_hit)
							span_open = 1'b1;
					end else if (nest_depth == 2) begin
						r.last    = 1'b1;
						span_open = 1'b0;
						parse_st  = ST_DONE;
					end
					nest_depth--;
					open_kind = (nest_depth == 0) ? KIND_UNKNOWN : KIND_CONTAINER;
					str_left  = '0;
					word_hit  = 1'b0;
				end
			end
		end
		r.st = parse_st;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stream construction
	// ------------------------------------------------------------------

	function automatic logic [7:0] pick_case(logic [7:0] lo, logic [7:0] up);
		return ($urandom_range(0, 3) == 0) ? up : lo;
	endfunction

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++)
			frame.push_back(s[i]);
	endtask

	// A string element whose body may hold any byte value.
	task automatic put_string(int len);
		put_text($sformatf("%0d:", len));
		for (int i = 0; i < len; i++)
			frame.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic put_int();
		int n;
		int r;
		n = $urandom_range(0, 5);
		frame.push_back(pick_case(CH_I_LO, CH_I_UP));
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 10);
			frame.push_back((r == 10) ? CH_MINUS : 8'(CH_ZERO + r));
		end
		frame.push_back(pick_case(CH_E_LO, CH_E_UP));
	endtask

	task automatic put_element(int levels);
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 40 || (levels == 0 && r >= 65))
			put_string(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6));
		else if (r < 65)
			put_int();
		else begin
			frame.push_back($urandom_range(0, 1) ? pick_case(CH_L_LO, CH_L_UP)
				: pick_case(CH_D_LO, CH_D_UP));
			n = $urandom_range(0, 4);
			for (int i = 0; i < n; i++)
				put_element(levels - 1);
			frame.push_back(pick_case(CH_E_LO, CH_E_UP));
		end
	endtask

	// Mostly the real key, at times with a leading zero in its length; sometimes near misses that must not open the span.
	task automatic put_info_key();
		case ($urandom_range(0, 9))
			7: put_text("04:info");
			8: put_text("4:INFO");
			9: begin
				case ($urandom_range(0, 2))
					0: put_text("4:infx");
					1: put_text("5:infoo");
					default: put_text("3:inf");
				endcase
			end
			default: put_text("4:info");
		endcase
	endtask

	// Moves the first keep bytes of the frame to the request queue.
	task automatic flush_frame(int keep);
		for (int i = 0; i < keep && i < frame.size(); i++)
			pending_reqs.push_back('{data: frame[i], restart: (i == 0)});
		frame.delete();
	endtask

	task automatic build_stream();
		int sel;
		int n;
		int info_at;
		int pos;
		int levels;
		sel = $urandom_range(0, 99);
		frame.delete();
		if (sel < 60 || sel >= 92) begin
			// Dictionary root with a handful of pairs, usually one of them keyed "info".
			frame.push_back(pick_case(CH_D_LO, CH_D_UP));
			n = $urandom_range(0, 4);
			info_at = ($urandom_range(0, 4) == 0) ? -1 : $urandom_range(0, n);
			for (int k = 0; k <= n; k++) begin
				if (k == info_at)
					put_info_key();
				else
					put_string($urandom_range(0, 6));
				put_element(2);
			end
			frame.push_back(pick_case(CH_E_LO, CH_E_UP));
			// Bytes past the end: ignored after success, a failure after a plain root.
			if ($urandom_range(0, 3) == 0)
				frame.push_back(8'($urandom_range(0, 255)));
			if (sel >= 92) begin
				// Cut short; the next stream restarts the parse, possibly mid-span.
				flush_frame($urandom_range(1, frame.size()));
			end else if ($urandom_range(0, 6) == 0) begin
				// One corrupted byte, then only a little of what follows.
				pos = $urandom_range(0, frame.size() - 1);
				frame[pos] = 8'($urandom_range(0, 255));
				flush_frame(pos + 1 + $urandom_range(0, 2));
			end else
				flush_frame(frame.size());
		end else if (sel < 68) begin
			// Length field right at its limit; the last digit decides overflow.
			frame.push_back(pick_case(CH_D_LO, CH_D_UP));
			if ($urandom_range(0, 2) == 0)
				put_text("000");
			put_text($sformatf("%0d", LEN_MAX / 10));
			frame.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
			if ($urandom_range(0, 1))
				frame.push_back(8'($urandom_range(0, 255)));
			frame.push_back(CH_COLON);
			frame.push_back(8'($urandom_range(0, 255)));
			frame.push_back(8'($urandom_range(0, 255)));
			flush_frame(frame.size());
		end else if (sel < 74) begin
			// Nesting around the depth limit, with or without the span spread across it.
			frame.push_back(pick_case(CH_D_LO, CH_D_UP));
			if ($urandom_range(0, 1))
				put_text("4:info");
			levels = $urandom_range(MAX_DEPTH - 3, MAX_DEPTH + 1);
			for (int i = 1; i < levels; i++)
				frame.push_back($urandom_range(0, 1) ? pick_case(CH_L_LO, CH_L_UP)
					: pick_case(CH_D_LO, CH_D_UP));
			put_int();
			for (int i = 0; i < levels; i++)
				frame.push_back(pick_case(CH_E_LO, CH_E_UP));
			flush_frame(frame.size());
		end else if (sel < 84) begin
			// Noise, with start_of_stream at random.
			n = $urandom_range(1, 8);
			for (int i = 0; i < n; i++)
				pending_reqs.push_back('{data: 8'($urandom_range(0, 255)),
					restart: 1'($urandom_range(0, 1))});
		end else begin
			// A root of any element kind, then possibly bytes after it.
			put_element(2);
			n = $urandom_range(0, 2);
			for (int i = 0; i < n; i++)
				frame.push_back(8'($urandom_range(0, 255)));
			flush_frame(frame.size());
		end
	endtask

	// ------------------------------------------------------------------
	// Pacing
	// ------------------------------------------------------------------

	// Idle cycles after a request; now and then pacing switches to back-to-back traffic.
	function automatic int sender_gap();
		int r;
		if ($urandom_range(0, 149) == 0)
			send_calm = !send_calm;
		if (send_calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int receiver_stall();
		int r;
		if ($urandom_range(0, 149) == 0)
			recv_calm = !recv_calm;
		if (recv_calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(string what, int got, int exp_val);
		mismatches++;
		$display("mismatch on result %0d: %s is %0d, expected %0d",
			result_count, what, got, exp_val);
	endtask

	// ------------------------------------------------------------------
	// Request driver: a request is accepted when in_valid is high and in_stall low at a
	// rising edge. Its flags are predicted at that edge, so the prediction follows the
	// order in which the block takes bytes.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= 8'h00;
			start_of_stream <= 1'b0;
			send_gap <= 0;
			clear_parse();
		end else begin
			if (in_valid && !in_stall)
				span_flags_due.push_back(locate_span_byte(data_byte, start_of_stream));
			// A stalled request keeps its payload; otherwise move on.
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					next_req = pending_reqs.pop_front();
					in_valid <= 1'b1;
					data_byte <= next_req.data;
					start_of_stream <= next_req.restart;
					send_gap <= sender_gap();
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: each accepted result is compared field by field with the oldest
	// prediction. The stall pattern is independent of out_valid.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				result_count++;
				if (span_flags_due.size() == 0)
					report_mismatch("result with no request waiting, status",
						int'(status), 0);
				else begin
					want = span_flags_due.pop_front();
					if (hash_byte !== want.hash)
						report_mismatch("hash_byte", int'(hash_byte), int'(want.hash));
					if (last_hash_byte !== want.last)
						report_mismatch("last_hash_byte", int'(last_hash_byte),
							int'(want.last));
					if (status !== want.st)
						report_mismatch("status", int'(status), int'(want.st));
				end
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else begin
				out_stall <= 1'b0;
				stall_left <= receiver_stall();
			end
		end
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL bencode_info_span_locator_unit");
		$finish;
	end

	initial begin
		// Directed streams first: an empty string as the info value (the span closes on
		// its colon and the trailing close is ignored), an empty root string followed by
		// a byte after the root, an upper case integer root with a stray close after it,
		// the lowest and highest byte values as opening bytes, and a list as the info value.
		put_text("d4:info0:e");
		flush_frame(frame.size());
		put_text("0:x");
		flush_frame(frame.size());
		put_text("I-5Ee");
		flush_frame(frame.size());
		frame.push_back(8'h00);
		flush_frame(1);
		frame.push_back(8'hFF);
		flush_frame(1);
		put_text("D4:infoLi-09EI0eee");
		flush_frame(frame.size());

		while (pending_reqs.size() < ITEM_TARGET)
			build_stream();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || in_valid)
			@(posedge clk);
		while (span_flags_due.size() != 0)
			@(posedge clk);
		// Run on to catch any result beyond the last one predicted.
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("PASS bencode_info_span_locator_unit");
		else
			$display("FAIL bencode_info_span_locator_unit");
		$finish;
	end

endmodule
